// ===== sv/fsp_pkg.sv =====
// ============================================================================
// fsp_pkg - Fibonacci sphere point generator shared definitions
// Pipeline control struct, lattice constants and the CORDIC arctangent table.
// ============================================================================
package fsp_pkg;

    // Control that travels alongside every pipeline stage
    typedef struct packed {
        logic valid;
        logic err;
    } ctl_t;

    // round(2^32 * (3 - sqrt 5) / 2): golden angle as a turn fraction
    localparam logic [31:0] GOLDEN_TURN     = 32'h61C8_8647;
    // round(2^32 * 0.60725293500888): inverse CORDIC gain
    localparam logic [31:0] CORDIC_INV_GAIN = 32'h9B74_EDA8;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'h2000_0000;
            5'd1:    a = 32'h12E4_051D;
            5'd2:    a = 32'h09FB_385B;
            5'd3:    a = 32'h0511_11D4;
            5'd4:    a = 32'h028B_0D43;
            5'd5:    a = 32'h0145_D7E1;
            5'd6:    a = 32'h00A2_F61E;
            5'd7:    a = 32'h0051_7C55;
            5'd8:    a = 32'h0028_BE53;
            5'd9:    a = 32'h0014_5F2F;
            5'd10:   a = 32'h000A_2F98;
            5'd11:   a = 32'h0005_17CC;
            5'd12:   a = 32'h0002_8BE6;
            5'd13:   a = 32'h0001_45F3;
            5'd14:   a = 32'h0000_A2F9;
            5'd15:   a = 32'h0000_517C;
            5'd16:   a = 32'h0000_28BE;
            5'd17:   a = 32'h0000_145F;
            5'd18:   a = 32'h0000_0A2F;
            5'd19:   a = 32'h0000_0517;
            5'd20:   a = 32'h0000_028B;
            5'd21:   a = 32'h0000_0145;
            5'd22:   a = 32'h0000_00A2;
            5'd23:   a = 32'h0000_0051;
            5'd24:   a = 32'h0000_0028;
            5'd25:   a = 32'h0000_0014;
            5'd26:   a = 32'h0000_000A;
            5'd27:   a = 32'h0000_0005;
            5'd28:   a = 32'h0000_0002;
            5'd29:   a = 32'h0000_0001;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/fsp_if.sv =====
// ============================================================================
// fsp_if - Valid/ready channels of the Fibonacci sphere point generator
// Index request channel and point result channel.
// ============================================================================
interface fsp_idx_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_index;

    modport source (output valid, output point_index, input ready);
    modport sink   (input valid, input point_index, output ready);
endinterface

interface fsp_pt_if;
    logic        valid;
    logic        ready;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
    logic        index_error;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output index_error, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input index_error, output ready);
endinterface

// ===== sv/fsp_div_cell.sv =====
// ============================================================================
// fsp_div_cell - One restoring-division step
// Shifts in one numerator bit, trial-subtracts the divisor, emits a quotient bit.
// ============================================================================
module fsp_div_cell
    import fsp_pkg::*;
#(
    parameter int IW = 16,
    parameter int QW = 16,
    parameter int SW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctl_t          ctl_in,
    input  logic [IW-1:0] den_in,
    input  logic [IW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [QW-1:0] quo_in,
    input  logic [SW-1:0] side_in,
    output ctl_t          ctl_out,
    output logic [IW-1:0] den_out,
    output logic [IW-1:0] rem_out,
    output logic [QW-1:0] low_out,
    output logic [QW-1:0] quo_out,
    output logic [SW-1:0] side_out
);

    ctl_t          ctl_reg;
    logic [IW-1:0] den_reg, rem_reg, rem_next;
    logic [QW-1:0] low_reg, quo_reg, quo_next;
    logic [SW-1:0] side_reg;
    logic [IW:0]   trial, diff;
    logic          ge;

    always_comb
    begin
        trial    = {rem_in, low_in[QW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[IW-1:0] : trial[IW-1:0];
        quo_next = {quo_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            low_reg  <= {low_in[QW-2:0], 1'b0};
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign low_out  = low_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/fsp_sqrt_cell.sv =====
// ============================================================================
// fsp_sqrt_cell - One digit step of the integer square root
// Resolves one root bit; the trial bit weight is fixed by the cell position.
// ============================================================================
module fsp_sqrt_cell
    import fsp_pkg::*;
#(
    parameter int F    = 14,
    parameter int STEP = 0,
    parameter int SW   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ctl_t              ctl_in,
    input  logic [2*F+1:0]    rem_in,
    input  logic [2*F+1:0]    res_in,
    input  logic [SW-1:0]     side_in,
    output ctl_t              ctl_out,
    output logic [2*F+1:0]    rem_out,
    output logic [2*F+1:0]    res_out,
    output logic [SW-1:0]     side_out
);

    localparam int SQW = 2 * F + 2;
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (F - STEP));

    ctl_t           ctl_reg;
    logic [SQW-1:0] rem_reg, res_reg, rem_next, res_next, sum;
    logic [SW-1:0]  side_reg;
    logic           ge;

    always_comb
    begin
        sum = res_in + BIT;
        ge  = (rem_in >= sum);
        if (ge)
        begin
            rem_next = rem_in - sum;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign res_out  = res_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/fsp_cordic_cell.sv =====
// ============================================================================
// fsp_cordic_cell - One CORDIC rotation-mode micro-rotation
// Shift-add rotation by +/- atan(2^-STEP), residual angle in turn units.
// ============================================================================
module fsp_cordic_cell
    import fsp_pkg::*;
#(
    parameter int CW   = 34,
    parameter int STEP = 0,
    parameter int SW   = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ctl_t                 ctl_in,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [32:0]   z_in,
    input  logic [SW-1:0]        side_in,
    output ctl_t                 ctl_out,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [32:0]   z_out,
    output logic [SW-1:0]        side_out
);

    localparam logic signed [32:0] ATAN = {1'b0, atan_turn(5'(STEP))};

    ctl_t                 ctl_reg;
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [32:0]   z_reg, z_next;
    logic [SW-1:0]        side_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/fibonacci_sphere_point_generator.sv =====
// ============================================================================
// fibonacci_sphere_point_generator - Fibonacci lattice point on the unit sphere
// Index in, (x, y, z) in signed Q1.FRAC_BITS out; one per cycle unless stalled.
// ============================================================================
// Each index transaction yields exactly one point transaction, in order. The
// block is a single stall-together pipeline built from chains of identical
// cells: FRAC_BITS+2 division cells, FRAC_BITS+1 square-root cells and
// CORDIC_STAGES rotation cells, plus six single stages (input, height and
// angle fold, square, root rounding, gain multiply, output). It accepts one
// index every cycle while the output is taken. The whole pipe freezes only
// while a finished point waits at the output with ready low.
// point_count is sampled when the index enters; write it only while idle.
// An index at or beyond point_count returns zero coordinates with index_error.
module fibonacci_sphere_point_generator
    import fsp_pkg::*;
#(
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16,
    parameter int INDEX_BITS    = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    fsp_idx_if.sink      idx,
    fsp_pt_if.source     pt
);

    // ---------------------------------------------------------------- widths
    localparam int F   = FRAC_BITS;
    localparam int IW  = (INDEX_BITS < 16) ? INDEX_BITS : 16;  // usable index bits
    localparam int QW  = F + 2;             // quotient / height width
    localparam int NW  = IW + F + 2;        // division numerator width
    localparam int SQW = 2 * F + 2;         // square-root working width
    localparam int CW  = F + 20;            // CORDIC datapath width
    localparam int PW  = IW + 32;           // index * golden product width
    localparam int GW  = F + 33;            // root * gain product width
    localparam int SDS = 2 + 33 + QW;       // sqrt side: quadrant, angle, height
    localparam int SCS = 2 + QW;            // CORDIC side: quadrant, height

    // ---------------------------------------------------------------- config
    logic [15:0] point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 16'd1024;
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------- flow control
    // All stages advance together whenever the output register is free or
    // being drained this cycle.
    logic out_valid_reg;
    logic adv;

    assign adv       = !out_valid_reg || pt.ready;
    assign idx.ready = adv;

    // ------------------------------------------------------- stage 0: input
    logic [IW-1:0] i_in, n_in;
    logic [PW-1:0] golden_prod;
    logic [NW-1:0] num_next;
    ctl_t          s0_ctl_reg;
    logic [IW-1:0] s0_den_reg;
    logic [NW-1:0] s0_num_reg;
    logic [31:0]   s0_ang_reg;

    always_comb
    begin
        i_in        = idx.point_index[IW-1:0];
        n_in        = point_count_reg[IW-1:0];
        // (2i+1) * 2^F + floor(n/2): rounds the quotient to nearest
        num_next    = (NW'({i_in, 1'b1}) << F) + NW'(n_in >> 1);
        golden_prod = PW'(i_in) * PW'(GOLDEN_TURN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s0_ctl_reg.valid <= idx.valid;
            s0_ctl_reg.err   <= (i_in >= n_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_den_reg <= n_in;
            s0_num_reg <= num_next;
            s0_ang_reg <= golden_prod[31:0];
        end
    end

    // ------------------------------------------------------- division chain
    // Quotient is known to be below 2^(F+2), so only QW steps are needed and
    // the numerator's top IW bits start out below the divisor.
    ctl_t          d_ctl  [0:QW];
    logic [IW-1:0] d_den  [0:QW];
    logic [IW-1:0] d_rem  [0:QW];
    logic [QW-1:0] d_low  [0:QW];
    logic [QW-1:0] d_quo  [0:QW];
    logic [31:0]   d_side [0:QW];

    assign d_ctl[0]  = s0_ctl_reg;
    assign d_den[0]  = s0_den_reg;
    assign d_rem[0]  = s0_num_reg[NW-1:QW];
    assign d_low[0]  = s0_num_reg[QW-1:0];
    assign d_quo[0]  = '0;
    assign d_side[0] = s0_ang_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        fsp_div_cell #(
            .IW (IW),
            .QW (QW),
            .SW (32)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (d_ctl[k]),
            .den_in   (d_den[k]),
            .rem_in   (d_rem[k]),
            .low_in   (d_low[k]),
            .quo_in   (d_quo[k]),
            .side_in  (d_side[k]),
            .ctl_out  (d_ctl[k+1]),
            .den_out  (d_den[k+1]),
            .rem_out  (d_rem[k+1]),
            .low_out  (d_low[k+1]),
            .quo_out  (d_quo[k+1]),
            .side_out (d_side[k+1])
        );
    end

    // ------------------------------------- stage 1: height and angle fold
    // Fold the azimuth by the nearest quarter turn into [-1/8, 1/8) turn.
    logic [31:0]           fold_sum, fold_z;
    ctl_t                  s1_ctl_reg;
    logic signed [QW-1:0]  s1_y_reg;
    logic [1:0]            s1_q_reg;
    logic signed [32:0]    s1_z_reg;

    always_comb
    begin
        fold_sum = d_side[QW] + 32'h2000_0000;
        fold_z   = d_side[QW] - {fold_sum[31:30], 30'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= d_ctl[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_y_reg <= $signed(d_quo[QW] - (QW'(1) << F));
            s1_q_reg <= fold_sum[31:30];
            s1_z_reg <= 33'($signed(fold_z));
        end
    end

    // ------------------------------------------ stage 2: 1 - y^2 operand
    logic signed [2*QW-1:0] ysq;
    logic [2*QW-1:0]        rad_full;
    ctl_t                   s2_ctl_reg;
    logic [SQW-1:0]         s2_rad_reg;
    logic [SDS-1:0]         s2_side_reg;

    always_comb
    begin
        ysq      = s1_y_reg * s1_y_reg;
        rad_full = ((2 * QW)'(1) << (2 * F)) - $unsigned(ysq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rad_reg  <= rad_full[SQW-1:0];
            s2_side_reg <= {s1_q_reg, s1_z_reg, s1_y_reg};
        end
    end

    // -------------------------------------------------- square-root chain
    ctl_t           r_ctl  [0:F+1];
    logic [SQW-1:0] r_rem  [0:F+1];
    logic [SQW-1:0] r_res  [0:F+1];
    logic [SDS-1:0] r_side [0:F+1];

    assign r_ctl[0]  = s2_ctl_reg;
    assign r_rem[0]  = s2_rad_reg;
    assign r_res[0]  = '0;
    assign r_side[0] = s2_side_reg;

    for (genvar k = 0; k <= F; k++)
    begin : g_sqrt
        fsp_sqrt_cell #(
            .F    (F),
            .STEP (k),
            .SW   (SDS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (r_ctl[k]),
            .rem_in   (r_rem[k]),
            .res_in   (r_res[k]),
            .side_in  (r_side[k]),
            .ctl_out  (r_ctl[k+1]),
            .rem_out  (r_rem[k+1]),
            .res_out  (r_res[k+1]),
            .side_out (r_side[k+1])
        );
    end

    // --------------------------------------------- stage 3: round the root
    logic [SQW-1:0] root_rnd;
    ctl_t           s3_ctl_reg;
    logic [F:0]     s3_r_reg;
    logic [SDS-1:0] s3_side_reg;

    assign root_rnd = (r_rem[F+1] > r_res[F+1]) ? r_res[F+1] + SQW'(1) : r_res[F+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s3_ctl_reg <= r_ctl[F+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_r_reg    <= root_rnd[F:0];
            s3_side_reg <= r_side[F+1];
        end
    end

    // ------------------------------------ stage 4: pre-scale by CORDIC gain
    logic [GW-1:0]        gain_prod;
    ctl_t                 s4_ctl_reg;
    logic signed [CW-1:0] s4_x_reg;
    logic signed [32:0]   s4_z_reg;
    logic [SCS-1:0]       s4_side_reg;

    assign gain_prod = GW'(s3_r_reg) * GW'(CORDIC_INV_GAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_x_reg    <= $signed(CW'(gain_prod >> 16));
            s4_z_reg    <= s3_side_reg[QW +: 33];
            s4_side_reg <= {s3_side_reg[SDS-1 -: 2], s3_side_reg[QW-1:0]};
        end
    end

    // -------------------------------------------------------- CORDIC chain
    localparam int NC = CORDIC_STAGES;

    ctl_t                 c_ctl  [0:NC];
    logic signed [CW-1:0] c_x    [0:NC];
    logic signed [CW-1:0] c_y    [0:NC];
    logic signed [32:0]   c_z    [0:NC];
    logic [SCS-1:0]       c_side [0:NC];

    assign c_ctl[0]  = s4_ctl_reg;
    assign c_x[0]    = s4_x_reg;
    assign c_y[0]    = '0;
    assign c_z[0]    = s4_z_reg;
    assign c_side[0] = s4_side_reg;

    for (genvar k = 0; k < NC; k++)
    begin : g_cordic
        fsp_cordic_cell #(
            .CW   (CW),
            .STEP (k),
            .SW   (SCS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (c_ctl[k]),
            .x_in     (c_x[k]),
            .y_in     (c_y[k]),
            .z_in     (c_z[k]),
            .side_in  (c_side[k]),
            .ctl_out  (c_ctl[k+1]),
            .x_out    (c_x[k+1]),
            .y_out    (c_y[k+1]),
            .z_out    (c_z[k+1]),
            .side_out (c_side[k+1])
        );
    end

    // ---------------------------------- stage 5: quadrant, round and output
    // Round (v + 2^15) >>> 16, clamp to [-1, 1], keep the low 16 bits.
    function automatic logic [15:0] finish_coord(input logic signed [CW:0] v);
        logic signed [CW:0] t;
        logic signed [CW:0] one;
        begin
            one = (CW + 1)'(1) << F;
            t   = (v + (CW + 1)'(32768)) >>> 16;
            if (t > one)
            begin
                t = one;
            end
            if (t < -one)
            begin
                t = -one;
            end
            return t[15:0];
        end
    endfunction

    logic signed [CW:0]     xe, ye, cos_v, sin_v;
    logic [1:0]             quad;
    logic signed [QW+15:0]  y_ext;
    logic [15:0]            x_next, y_next, z_next;

    always_comb
    begin
        xe    = (CW + 1)'(c_x[NC]);
        ye    = (CW + 1)'(c_y[NC]);
        quad  = c_side[NC][SCS-1 -: 2];
        y_ext = (QW + 16)'($signed(c_side[NC][QW-1:0]));
        case (quad)
            2'd0:
            begin
                cos_v = xe;
                sin_v = ye;
            end
            2'd1:
            begin
                cos_v = -ye;
                sin_v = xe;
            end
            2'd2:
            begin
                cos_v = -xe;
                sin_v = -ye;
            end
            default:
            begin
                cos_v = ye;
                sin_v = -xe;
            end
        endcase
        if (c_ctl[NC].err)
        begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
        else
        begin
            x_next = finish_coord(cos_v);
            y_next = y_ext[15:0];
            z_next = finish_coord(sin_v);
        end
    end

    logic [15:0] coord_x_reg, coord_y_reg, coord_z_reg;
    logic        index_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c_ctl[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coord_x_reg     <= x_next;
            coord_y_reg     <= y_next;
            coord_z_reg     <= z_next;
            index_error_reg <= c_ctl[NC].err;
        end
    end

    assign pt.valid       = out_valid_reg;
    assign pt.coord_x     = coord_x_reg;
    assign pt.coord_y     = coord_y_reg;
    assign pt.coord_z     = coord_z_reg;
    assign pt.index_error = index_error_reg;

endmodule
